### rtl/glbb_pkg.sv
// shared types and constants for the greedy load balance binder
package glbb_pkg;

   localparam int ID_W      = 16;
   localparam int WL_W      = 32;
   localparam int THR_OUT_W = 4;
   localparam int CSR_W     = 5;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [WL_W-1:0] wl;
   } task_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_FIT_MUL,
      ST_FIT_CMP,
      ST_EMIT
   } glbb_state_type;

endpackage

### rtl/glbb_task_mem.sv
// task store: one write port, one registered read port
module glbb_task_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  glbb_pkg::task_entry_type wr_data,
   input  logic [AW-1:0]           rd_addr,
   output glbb_pkg::task_entry_type rd_data
);
   import glbb_pkg::*;

   task_entry_type mem [DEPTH];
   task_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/glbb_fit_unit.sv
// shared capacity test: threads * (load + workload) <= total, product registered
module glbb_fit_unit #(
   parameter int LW = 39,
   parameter int CW = 5
) (
   input  logic                      clock,
   input  logic                      load_en,
   input  logic [LW-1:0]             thread_load,
   input  logic [glbb_pkg::WL_W-1:0] workload,
   input  logic [CW-1:0]             threads,
   input  logic [LW-1:0]             total,
   output logic                      fits
);
   import glbb_pkg::*;

   localparam int PW = LW + 1 + CW;

   logic [LW:0]   sum;
   logic [PW-1:0] prod_ff;
   logic [PW-1:0] prod_in;

   assign sum     = (LW+1)'(thread_load) + (LW+1)'(workload);
   assign prod_in = PW'(sum) * PW'(threads);

   always_ff @(posedge clock) begin
      if (load_en) begin
         prod_ff <= prod_in;
      end
   end

   assign fits = prod_ff <= PW'(total);
endmodule

### rtl/greedy_load_balance_binder.sv
// greedy load balance binder top level: loader, selection sequencer and binding
// Tasks load one word per cycle while idle. The word with last set starts the
// binding: for each of the n stored tasks the sequencer scans the task store, one
// store read per cycle, to pick the heaviest unbound task, earliest arrival
// first on ties, then places it: the first t tasks directly, later ones
// first-fit through the shared capacity unit, and after the first task that
// fits nowhere round-robin. Each binding is offered as one result word before
// the next scan starts; no new task is taken until the last result word of
// the set has been accepted.
module greedy_load_balance_binder #(
   parameter int MAX_TASKS   = 64,
   parameter int MAX_THREADS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [glbb_pkg::ID_W-1:0]     req_task_id,
   input  logic [glbb_pkg::WL_W-1:0]     req_workload,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [glbb_pkg::ID_W-1:0]     rsp_task_id_res,
   output logic [glbb_pkg::THR_OUT_W-1:0] rsp_thread,
   output logic                          rsp_last_out,
   input  logic                          csr_we,
   input  logic [glbb_pkg::CSR_W-1:0]    csr_wdata
);
   import glbb_pkg::*;

   localparam int CNTW = $clog2(MAX_TASKS + 1);
   localparam int AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW   = $clog2(MAX_THREADS + 1);
   localparam int TW   = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int LW   = WL_W + CNTW;

   glbb_state_type state_ff, state_in;

   logic [CSR_W-1:0] num_threads_ff;
   logic [CNTW-1:0]  count_ff, n_ff, pos_ff, scan_cnt_ff;
   logic [LW-1:0]    total_ff;
   logic [CW-1:0]    t_ff;
   logic             scan_vld_ff, found_ff, ovf_ff;
   logic [AW-1:0]    scan_idx_ff, best_idx_ff;
   logic [WL_W-1:0]  best_wl_ff;
   logic [ID_W-1:0]  best_id_ff;
   logic [TW-1:0]    ptr_ff, j_ff;
   logic [MAX_TASKS-1:0] used_ff;
   logic [LW-1:0]    load_ff [MAX_THREADS];

   logic             rsp_valid_ff;
   logic [ID_W-1:0]  rsp_id_ff;
   logic [THR_OUT_W-1:0] rsp_thr_ff;
   logic             rsp_last_ff;

   // control decoded from state
   logic req_take, scan_issue, scan_done, fit_load, fits, emit_done, last_pos;
   logic store_room;
   logic [CW-1:0] t_clamp;
   logic [TW-1:0] thr_sel, ptr_next;
   logic [LW-1:0] load_rd;
   task_entry_type wr_entry, rd_entry;

   assign store_room = count_ff < CNTW'(MAX_TASKS);
   assign req_take   = (state_ff == ST_IDLE) && req_valid && !req_stall;
   assign scan_done  = (scan_cnt_ff == n_ff) && !scan_vld_ff;
   assign emit_done  = rsp_valid_ff && !rsp_stall;
   assign last_pos   = (pos_ff + CNTW'(1)) == n_ff;
   assign ptr_next   = ((CW'(ptr_ff) + CW'(1)) == t_ff) ? '0 : ptr_ff + TW'(1);
   assign thr_sel    = (state_ff == ST_PLACE) ? TW'(pos_ff) : j_ff;
   assign load_rd    = load_ff[thr_sel];

   always_comb begin
      if (num_threads_ff == '0) begin
         t_clamp = CW'(1);
      end else if (int'(num_threads_ff) > MAX_THREADS) begin
         t_clamp = CW'(MAX_THREADS);
      end else begin
         t_clamp = CW'(num_threads_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_PLACE;
         end
         ST_PLACE: begin
            if (32'(pos_ff) < 32'(t_ff) || ovf_ff) state_in = ST_EMIT;
            else state_in = ST_FIT_MUL;
         end
         ST_FIT_MUL: state_in = ST_FIT_CMP;
         ST_FIT_CMP: begin
            if (fits || (CW'(j_ff) + CW'(1)) == t_ff) state_in = ST_EMIT;
            else state_in = ST_FIT_MUL;
         end
         ST_EMIT: begin
            if (emit_done) state_in = last_pos ? ST_IDLE : ST_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall  = 1'b1;
      scan_issue = 1'b0;
      fit_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_stall = 1'b0;
         ST_SCAN:    scan_issue = scan_cnt_ff < n_ff;
         ST_FIT_MUL: fit_load = 1'b1;
         ST_PLACE, ST_FIT_CMP, ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   assign wr_entry.id = req_task_id;
   assign wr_entry.wl = req_workload;

   glbb_task_mem #(.DEPTH(MAX_TASKS), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (req_take && store_room),
      .wr_addr (AW'(count_ff)),
      .wr_data (wr_entry),
      .rd_addr (AW'(scan_cnt_ff)),
      .rd_data (rd_entry)
   );

   glbb_fit_unit #(.LW(LW), .CW(CW)) u_fit (
      .clock       (clock),
      .load_en     (fit_load),
      .thread_load (load_rd),
      .workload    (best_wl_ff),
      .threads     (t_ff),
      .total       (total_ff),
      .fits        (fits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         num_threads_ff <= CSR_W'(1);
         count_ff       <= '0;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         scan_vld_ff    <= 1'b0;
         found_ff       <= 1'b0;
         ovf_ff         <= 1'b0;
         ptr_ff         <= '0;
         pos_ff         <= '0;
         scan_cnt_ff    <= '0;
         n_ff           <= '0;
         t_ff           <= CW'(1);
         j_ff           <= '0;
         used_ff        <= '0;
         for (int k = 0; k < MAX_THREADS; k++) load_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) num_threads_ff <= csr_wdata;

         // loading, and start of a binding
         if (req_take) begin
            if (store_room) begin
               count_ff <= count_ff + CNTW'(1);
               total_ff <= total_ff + LW'(req_workload);
            end
            if (req_last) begin
               n_ff        <= store_room ? count_ff + CNTW'(1) : count_ff;
               t_ff        <= t_clamp;
               pos_ff      <= '0;
               ovf_ff      <= 1'b0;
               ptr_ff      <= '0;
               used_ff     <= '0;
               scan_cnt_ff <= '0;
               scan_vld_ff <= 1'b0;
               found_ff    <= 1'b0;
               for (int k = 0; k < MAX_THREADS; k++) load_ff[k] <= '0;
            end
         end

         // selection scan: heaviest unused entry, earliest wins ties
         if (state_ff == ST_SCAN) begin
            scan_vld_ff <= scan_issue;
            scan_idx_ff <= AW'(scan_cnt_ff);
            if (scan_issue) scan_cnt_ff <= scan_cnt_ff + CNTW'(1);
            if (scan_vld_ff && !used_ff[scan_idx_ff] &&
                (!found_ff || rd_entry.wl > best_wl_ff)) begin
               found_ff    <= 1'b1;
               best_wl_ff  <= rd_entry.wl;
               best_id_ff  <= rd_entry.id;
               best_idx_ff <= scan_idx_ff;
            end
         end

         if (state_ff == ST_PLACE) begin
            used_ff[best_idx_ff] <= 1'b1;
            j_ff <= '0;
            if (32'(pos_ff) < 32'(t_ff)) begin
               load_ff[thr_sel] <= load_rd + LW'(best_wl_ff);
               rsp_thr_ff       <= THR_OUT_W'(thr_sel);
            end else if (ovf_ff) begin
               rsp_thr_ff <= THR_OUT_W'(ptr_ff);
               ptr_ff     <= ptr_next;
            end
         end

         if (state_ff == ST_FIT_CMP) begin
            if (fits) begin
               load_ff[thr_sel] <= load_rd + LW'(best_wl_ff);
               rsp_thr_ff       <= THR_OUT_W'(thr_sel);
            end else if ((CW'(j_ff) + CW'(1)) == t_ff) begin
               ovf_ff     <= 1'b1;
               rsp_thr_ff <= THR_OUT_W'(ptr_ff);
               ptr_ff     <= ptr_next;
            end else begin
               j_ff <= j_ff + TW'(1);
            end
         end

         // result word
         if (state_ff != ST_EMIT && state_in == ST_EMIT) begin
            rsp_valid_ff <= 1'b1;
            rsp_id_ff    <= best_id_ff;
            rsp_last_ff  <= last_pos;
         end
         if (state_ff == ST_EMIT && emit_done) begin
            rsp_valid_ff <= 1'b0;
            pos_ff       <= pos_ff + CNTW'(1);
            scan_cnt_ff  <= '0;
            scan_vld_ff  <= 1'b0;
            found_ff     <= 1'b0;
            if (last_pos) begin
               count_ff <= '0;
               total_ff <= '0;
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_task_id_res = rsp_id_ff;
   assign rsp_thread      = rsp_thr_ff;
   assign rsp_last_out    = rsp_last_ff;

   a_valid_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_EMIT)
      else $error("result word valid outside emit");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_TASKS))
      else $error("task count beyond store depth");
   a_place_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLACE |-> found_ff && !used_ff[best_idx_ff])
      else $error("placement without a selected task");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> pos_ff < n_ff)
      else $error("sorted position past set size");
endmodule

### tb/glbb_checker.sv
// checker for the greedy load balance binder: predicts bindings and compares result words
`timescale 1ns / 1ps
module glbb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_task_id,
   input  logic [31:0] req_workload,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_task_id_res,
   input  logic [3:0]  rsp_thread,
   input  logic        rsp_last_out,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata,
   output int          fail_count,
   output int          pending
);
   localparam int MAX_TASKS = 64;
   localparam int MAX_THREADS = 16;

   typedef struct {
      logic [15:0] id;
      logic [3:0]  thr;
      logic        last;
   } binding_type;

   binding_type bind_q[$];
   logic [4:0]  thread_cfg;
   logic [15:0] set_id[MAX_TASKS];
   logic [31:0] set_wl[MAX_TASKS];
   int          set_n;
   logic [37:0] set_total;

   assign pending = bind_q.size();

   task automatic bind_set();
      int ord[MAX_TASKS];
      logic [3:0] thr[MAX_TASKS];
      logic [37:0] tload[MAX_THREADS];
      int t, k, j, p;
      logic over;
      logic [31:0] w;
      binding_type b;
      logic [43:0] lhs;
      t = thread_cfg == 0 ? 1 : (thread_cfg > MAX_THREADS ? MAX_THREADS : thread_cfg);
      for (int i = 0; i < set_n; i++) ord[i] = i;
      for (int i = 1; i < set_n; i++) begin
         k = ord[i];
         j = i;
         while (j > 0 && set_wl[ord[j-1]] < set_wl[k]) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = k;
      end
      for (int i = 0; i < MAX_THREADS; i++) tload[i] = '0;
      over = 0;
      p = 0;
      for (int i = 0; i < set_n; i++) begin
         w = set_wl[ord[i]];
         if (i < t) begin
            tload[i] = tload[i] + 38'(w);
            thr[i] = 4'(i);
         end else begin
            if (!over) begin
               for (j = 0; j < t; j++) begin
                  lhs = 44'(t) * (44'(tload[j]) + 44'(w));
                  if (lhs <= 44'(set_total)) begin
                     tload[j] = tload[j] + 38'(w);
                     thr[i] = 4'(j);
                     break;
                  end
               end
               if (j >= t) over = 1;
            end
            if (over) begin
               thr[i] = 4'(p);
               p = (p + 1) % t;
            end
         end
      end
      for (int i = 0; i < set_n; i++) begin
         b.id = set_id[ord[i]];
         b.thr = thr[i];
         b.last = (i + 1 == set_n);
         bind_q.push_back(b);
      end
      set_n = 0;
      set_total = '0;
   endtask

   always @(posedge clock) begin
      binding_type e;
      if (reset) begin
         thread_cfg <= 5'd1;
         set_n = 0;
         set_total = '0;
         fail_count <= 0;
         bind_q.delete();
      end else begin
         if (csr_we) thread_cfg <= csr_wdata;
         if (rsp_valid && !rsp_stall) begin
            if (bind_q.size() == 0) begin
               $display("%0t: unexpected word id=%h thread=%0d last=%b", $time,
                        rsp_task_id_res, rsp_thread, rsp_last_out);
               fail_count <= fail_count + 1;
            end else begin
               e = bind_q.pop_front();
               if (e.id !== rsp_task_id_res || e.thr !== rsp_thread ||
                   e.last !== rsp_last_out) begin
                  $display("%0t: mismatch expected id=%h thread=%0d last=%b actual id=%h thread=%0d last=%b",
                           $time, e.id, e.thr, e.last, rsp_task_id_res, rsp_thread,
                           rsp_last_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (set_n < MAX_TASKS) begin
               set_id[set_n] = req_task_id;
               set_wl[set_n] = req_workload;
               set_total = set_total + 38'(req_workload);
               set_n++;
            end
            if (req_last) bind_set();
         end
      end
   end
endmodule

### tb/tb_greedy_load_balance_binder.sv
// testbench top: stimulus for the greedy load balance binder and the final verdict
`timescale 1ns / 1ps
module tb_greedy_load_balance_binder;
   logic clock, reset;
   logic req_valid, req_stall, req_last;
   logic [15:0] req_task_id;
   logic [31:0] req_workload;
   logic rsp_valid, rsp_stall, rsp_last_out;
   logic [15:0] rsp_task_id_res;
   logic [3:0] rsp_thread;
   logic csr_we;
   logic [4:0] csr_wdata;
   int fail_count, pending;
   int send_idle_pct, recv_idle_pct;
   int hold_cycles;
   longint cycle_count;

   greedy_load_balance_binder dut (.*);
   glbb_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 3000000) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // receiver stall, with an optional long hold-off
   initial begin
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // valid stays up after the word until the next word replaces it; an idle cycle or drain lowers it
   task automatic send_word(input logic [15:0] id, input logic [31:0] wl, input logic lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_task_id <= id;
      req_workload <= wl;
      req_last <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_threads(input logic [4:0] v);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   function automatic logic [31:0] rand_wl();
      case ($urandom_range(4))
         0: return $urandom;
         1: return $urandom_range(7);
         2: return 32'h1_0000 * $urandom_range(4);
         default: return $urandom_range(32'h000F_FFFF);
      endcase
   endfunction

   task automatic random_set(input int n);
      for (int i = 0; i < n; i++) send_word(16'($urandom), rand_wl(), i == n - 1);
   endtask

   initial begin
      int sent, phase, n;
      bit held;
      reset = 1;
      req_valid = 0; req_task_id = 0; req_workload = 0; req_last = 0;
      csr_we = 0; csr_wdata = 0;
      hold_cycles = 0;
      send_idle_pct = 0; recv_idle_pct = 0;
      held = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: one thread, single task, extremes, ties
      send_word(16'hFFFF, 32'hFFFF_FFFF, 1);
      send_word(16'h0000, 32'h0, 0);
      send_word(16'h1234, 32'hFFFF_FFFF, 0);
      send_word(16'h1235, 32'h0, 1);
      drain();
      set_threads(5'd0);
      send_word(16'h0001, 32'd5, 0);
      send_word(16'h0002, 32'd5, 0);
      send_word(16'h0003, 32'd9, 1);
      drain();
      set_threads(5'd31);
      send_word(16'h0010, 32'd4, 0);
      send_word(16'h0011, 32'd8, 1);
      drain();
      set_threads(5'd3);
      send_word(16'hAAAA, 32'd10, 0);
      send_word(16'h5555, 32'd9, 0);
      send_word(16'h0101, 32'd8, 0);
      send_word(16'h0202, 32'd7, 0);
      send_word(16'h0303, 32'd6, 0);
      send_word(16'h0404, 32'd50, 0);
      send_word(16'h0505, 32'd1, 1);
      drain();
      // store full: 66 tasks with the last two dropped
      set_threads(5'd16);
      for (int i = 0; i < 66; i++) send_word(16'(i), rand_wl(), i == 65);
      drain();
      sent = 0;
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 37 : (phase == 1 ? 87 : 0);
         recv_idle_pct = phase == 0 ? 87 : (phase == 1 ? 37 : 0);
         while (sent < 130 * (phase + 1)) begin
            set_threads($urandom_range(3) == 0 ? 5'($urandom) : 5'($urandom_range(1, 4)));
            n = $urandom_range(9) == 0 ? $urandom_range(20, 64) : $urandom_range(1, 8);
            // long receiver hold-off while a second set queues behind the first
            if (phase == 2 && !held) begin
               hold_cycles = 400;
               held = 1;
               random_set(n);
               sent += n;
            end
            random_set(n);
            sent += n;
            drain();
         end
      end
      drain();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
